// File: rtl/core/cfe_pkg.sv
package cfe_pkg;

  localparam logic [7:0] DELIM_RESET = 8'h0A;
  localparam logic [7:0] CODE_START  = 8'h01;

  // output byte source
  localparam logic [1:0] SEL_CODE  = 2'd0;
  localparam logic [1:0] SEL_DATA  = 2'd1;
  localparam logic [1:0] SEL_DELIM = 2'd2;

  typedef struct packed {
    logic       take;       // input item accepted this cycle
    logic       rd_clear;   // restart group read at entry zero
    logic       rd_step;    // advance group read
    logic       clear_len;  // group closed, empty it
    logic [1:0] sel;        // output byte source
  } cfe_cmd_t;

  typedef struct packed {
    logic is_delim;     // incoming byte equals delimiter
    logic last_eff;     // incoming byte ends the frame
    logic group_empty;  // open group holds no bytes
    logic data_last;    // byte on the output is the group's last
  } cfe_status_t;

endpackage

// File: rtl/core/cfe_if.sv
interface cfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

// File: rtl/core/cobs_frame_encoder_core.sv
// Byte-stuffing frame encoder in the manner of COBS with a programmable
// delimiter (register 0 at address 0, reset 0x0A). Each input item is one
// payload byte plus a last flag. A byte equal to the delimiter closes the
// open group: the core sends a code byte (group length plus one) and then
// the held bytes; the delimiter itself is dropped. The frame's last byte
// closes the final group and is followed by the delimiter with frame_end
// set. A frame reaching FRAME_MAX bytes is ended at that byte. When the
// last byte is the delimiter, an empty group (code byte only) follows the
// closed group before the terminator. The output runs at one byte per
// cycle while the receiver keeps ready high; a new item is taken only once
// the previous item's bytes are all sent. Change the delimiter only while
// idle.
module cobs_frame_encoder_core #(
  parameter int FRAME_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  cfe_in_if.sink      in_ch,
  cfe_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfe_pkg::*;

  cfe_cmd_t    cmd;
  cfe_status_t status;
  logic        cfg_sel;
  logic        cfg_we;
  logic [7:0]  delimiter;

  // one register: address bit 2 set is beyond the map
  assign pready  = 1'b1;
  assign cfg_sel = !paddr[2];
  assign cfg_we  = psel && penable && pwrite && cfg_sel;
  assign prdata  = cfg_sel ? {24'd0, delimiter} : 32'd0;

  cfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cfe_dp #(
    .FRAME_MAX (FRAME_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .out_byte  (out_ch.out_byte),
    .frame_end (out_ch.frame_end),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[7:0]),
    .delimiter (delimiter)
  );

endmodule

// File: rtl/core/cfe_dp.sv
module cfe_dp #(
  parameter int FRAME_MAX = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  cfe_pkg::cfe_cmd_t   cmd,
  output cfe_pkg::cfe_status_t status,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic [7:0]          out_byte,
  output logic                frame_end,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  output logic [7:0]          delimiter
);
  import cfe_pkg::*;

  localparam int LW = $clog2(FRAME_MAX + 1);
  localparam int AW = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
  localparam logic [LW-1:0] LAST_POS = LW'(FRAME_MAX - 1);

  logic [7:0]    group_store [FRAME_MAX];
  logic [LW-1:0] group_length;
  logic [LW-1:0] frame_position;
  logic [LW-1:0] rd_idx;
  logic [LW-1:0] rd_idx_next;
  logic [7:0]    rd_data;
  logic          is_delim;
  logic          last_eff;

  assign is_delim = (data_byte == delimiter);
  // byte that fills the frame to its maximum is forced to be last
  assign last_eff = last_byte || (frame_position >= LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter      <= DELIM_RESET;
      group_length   <= '0;
      frame_position <= '0;
    end else begin
      if (cfg_we) begin
        delimiter <= cfg_wdata;
      end
      if (cmd.take) begin
        frame_position <= last_eff ? '0 : frame_position + LW'(1);
        if (!is_delim && (group_length < LW'(FRAME_MAX))) begin
          group_length <= group_length + LW'(1);
        end
      end else if (cmd.clear_len) begin
        group_length <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && !is_delim && (group_length < LW'(FRAME_MAX))) begin
      group_store[group_length[AW-1:0]] <= data_byte;
    end
  end

  always_comb begin
    priority if (cmd.rd_clear) begin
      rd_idx_next = '0;
    end else if (cmd.rd_step) begin
      rd_idx_next = rd_idx + LW'(1);
    end else begin
      rd_idx_next = rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx  <= rd_idx_next;
    rd_data <= group_store[rd_idx_next[AW-1:0]];
  end

  always_comb begin
    unique case (cmd.sel)
      SEL_CODE:  out_byte = 8'(group_length) + CODE_START;
      SEL_DATA:  out_byte = rd_data;
      SEL_DELIM: out_byte = delimiter;
      default:   out_byte = delimiter;
    endcase
  end

  assign frame_end = (cmd.sel == SEL_DELIM);

  assign status.is_delim    = is_delim;
  assign status.last_eff    = last_eff;
  assign status.group_empty = (group_length == '0);
  assign status.data_last   = ((rd_idx + LW'(1)) == group_length);

endmodule

// File: rtl/core/cfe_ctrl.sv
module cfe_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  cfe_pkg::cfe_status_t status,
  output cfe_pkg::cfe_cmd_t    cmd
);
  import cfe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CODE = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;
  localparam logic [1:0] ST_END  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       pend_extra;
  logic       pend_extra_next;
  logic       pend_last;
  logic       pend_last_next;
  logic       out_fire;
  logic       close_done;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state != ST_IDLE);
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    unique case (state)
      ST_CODE: close_done = out_fire && status.group_empty;
      ST_DATA: close_done = out_fire && status.data_last;
      default: close_done = 1'b0;
    endcase
  end

  always_comb begin
    state_next      = state;
    pend_extra_next = pend_extra;
    pend_last_next  = pend_last;
    cmd.take        = 1'b0;
    cmd.rd_clear    = 1'b0;
    cmd.rd_step     = 1'b0;
    cmd.clear_len   = close_done;
    cmd.sel         = SEL_CODE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take        = 1'b1;
          pend_last_next  = status.last_eff;
          pend_extra_next = status.is_delim && status.last_eff;
          if (status.is_delim || status.last_eff) begin
            state_next = ST_CODE;
          end
        end
      end
      ST_CODE: begin
        cmd.sel      = SEL_CODE;
        cmd.rd_clear = 1'b1;
        if (out_fire && !status.group_empty) begin
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        cmd.sel     = SEL_DATA;
        cmd.rd_step = out_fire;
      end
      ST_END: begin
        cmd.sel = SEL_DELIM;
        if (out_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    // group closed: an empty final group, the terminator, or back to idle
    if (close_done) begin
      priority if (pend_extra) begin
        pend_extra_next = 1'b0;
        state_next      = ST_CODE;
      end else if (pend_last) begin
        state_next = ST_END;
      end else begin
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_extra <= 1'b0;
      pend_last  <= 1'b0;
    end else begin
      state      <= state_next;
      pend_extra <= pend_extra_next;
      pend_last  <= pend_last_next;
    end
  end

`ifndef SYNTHESIS
  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while output busy");

  a_extra_needs_last: assert property (@(posedge clk) disable iff (rst)
    pend_extra |-> pend_last)
    else $error("extra group pending without frame end");

  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_END && out_fire) |=> (state == ST_IDLE))
    else $error("terminator sent but not idle");

  a_terminator_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_END) |-> (pend_last && !pend_extra))
    else $error("terminator without pending frame end");
`endif

endmodule

// File: tb/sv/cobs_frame_encoder_core_tb.sv
module cobs_frame_encoder_core_tb;
  import cfe_pkg::*;

  localparam int FRAME_MAX = 32;
  localparam logic [7:0] CODE_SPLIT = 8'hFF;  // group closed at 254 bytes, unreachable here

  // register indexes, byte address is 4 * index
  localparam int REG_DELIMITER = 0;
  localparam int REG_SPARE     = 1;  // unmapped, writes must be dropped

  localparam int MAX_WAIT      = 17;    // longest gap or stall drawn per item
  localparam int SETTLE_CYCLES = 4;     // margin after the queues drain
  localparam int TAIL_CYCLES   = 40;    // worst encoded burst is 34 bytes
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int PHASES        = 6;
  localparam int PHASE_BYTES   = 34;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } payload_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } coded_t;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  cfe_in_if  in_bus ();
  cfe_out_if out_bus ();

  cobs_frame_encoder_core #(
    .FRAME_MAX(FRAME_MAX)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  // raw bytes waiting to be sent, and encoded bytes waiting to come out
  payload_t pending_q [$];
  coded_t   coded_q [$];

  // encoder state as the predictor sees it
  logic [7:0] grp_buf [FRAME_MAX];
  logic [5:0] grp_len   = '0;
  logic [5:0] frame_pos = '0;
  logic [7:0] delim_reg = DELIM_RESET;

  bit no_idle = 1'b0;  // phase with back-to-back traffic on both sides
  int fail_cnt   = 0;
  int bytes_in   = 0;
  int bytes_out  = 0;
  int frames_out = 0;
  int writes     = 0;

  // code byte, then the held bytes in order; the group is emptied
  function automatic void emit_group();
    coded_t c;
    c.out_byte  = {2'b00, grp_len} + CODE_START;
    c.frame_end = 1'b0;
    coded_q.push_back(c);
    for (int i = 0; i < grp_len; i++) begin
      c.out_byte = grp_buf[i];
      coded_q.push_back(c);
    end
    grp_len = '0;
  endfunction

  // one accepted raw byte, appends whatever encoded bytes it releases
  function automatic void encode_byte(input logic [7:0] b, input logic lst);
    logic   ends;
    coded_t term;
    ends = lst;
    frame_pos = frame_pos + 6'd1;
    // overlong frame: the byte that fills the frame ends it regardless of the flag
    if (frame_pos >= FRAME_MAX) ends = 1'b1;
    if (b == delim_reg) begin
      emit_group();
    end else begin
      if (grp_len < FRAME_MAX) begin
        grp_buf[grp_len] = b;
        grp_len = grp_len + 6'd1;
      end
      if ({2'b00, grp_len} + CODE_START == CODE_SPLIT) emit_group();
    end
    // a delimiter as last byte leaves an empty group, closed here with code one
    if (ends) begin
      emit_group();
      term.out_byte  = delim_reg;
      term.frame_end = 1'b1;
      coded_q.push_back(term);
      frame_pos = '0;
    end
  endfunction

  // sender: a drawn gap follows every item, then the next pending byte goes out
  payload_t next_item;
  int       send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid     <= 1'b0;
      in_bus.data_byte <= '0;
      in_bus.last_byte <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        encode_byte(in_bus.data_byte, in_bus.last_byte);
        bytes_in++;
      end
      // slot is free once the current item is taken or none is shown
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap != 0) begin
          in_bus.valid <= 1'b0;
          send_gap--;
        end else if (pending_q.size() != 0) begin
          next_item = pending_q.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.data_byte <= next_item.data_byte;
          in_bus.last_byte <= next_item.last_byte;
          send_gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each encoded byte against the oldest prediction,
  // then holds ready low for a drawn number of cycles
  coded_t want;
  int     recv_stall = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (coded_q.size() == 0) begin
          $error("unexpected item: out_byte %h frame_end %b", out_bus.out_byte,
                 out_bus.frame_end);
          fail_cnt++;
        end else begin
          want = coded_q.pop_front();
          if (out_bus.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_bus.out_byte);
            fail_cnt++;
          end
          if (out_bus.frame_end !== want.frame_end) begin
            $error("frame_end: expected %b, got %b", want.frame_end, out_bus.frame_end);
            fail_cnt++;
          end
        end
        bytes_out++;
        if (out_bus.frame_end === 1'b1) frames_out++;
        recv_stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (recv_stall != 0) begin
        recv_stall--;
      end
      out_bus.ready <= (recv_stall == 0);
    end
  end

  // watchdog on cycles where neither channel nor the register port moves
  int quiet = 0;

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void push_byte(input logic [7:0] b, input logic lst);
    payload_t p;
    p.data_byte = b;
    p.last_byte = lst;
    pending_q.push_back(p);
  endfunction

  // wait until every byte is sent and every encoded byte has come back
  task automatic drain_block();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_bus.valid || coded_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write while idle; upper data bits carry noise the block must drop
  task automatic reg_write(input int idx, input logic [7:0] val);
    logic [31:0] word;
    word = $urandom;
    word[7:0] = val;
    drain_block();
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(idx * 4);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DELIMITER) delim_reg = val;
    writes++;
  endtask

  // mostly short frames, some past FRAME_MAX, and some with the last flag
  // dropped so that they run on into the next frame
  task automatic queue_frames(input int count);
    int         len;
    int         done;
    bit         cut;
    logic [7:0] b;
    done = 0;
    while (done < count) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 10);
      cut = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < len; i++) begin
        b = ($urandom_range(0, 3) == 0) ? delim_reg : 8'($urandom_range(0, 255));
        push_byte(b, (i == len - 1) && !cut);
      end
      done += len;
    end
  endtask

  initial begin
    logic [7:0] d;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset delimiter: extreme bytes around a delimiter in mid frame
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h0A, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b1);
    // delimiter alone as the last byte, then after one data byte
    push_byte(8'h0A, 1'b1);
    push_byte(8'h31, 1'b0);
    push_byte(8'h0A, 1'b1);
    // back-to-back delimiters give empty groups
    push_byte(8'h0A, 1'b0);
    push_byte(8'h0A, 1'b0);
    push_byte(8'h7E, 1'b1);

    // code bytes equal to the delimiter
    reg_write(REG_DELIMITER, 8'h01);
    push_byte(8'h01, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h01, 1'b1);

    // lowest and highest delimiter
    reg_write(REG_DELIMITER, 8'h00);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    reg_write(REG_DELIMITER, 8'hFF);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);

    // random frames, one delimiter setting per phase
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: d = DELIM_RESET;
        1: d = 8'h00;
        2: d = 8'hFF;
        3: d = 8'h01;
        default: d = 8'($urandom_range(0, 255));
      endcase
      if (p == 3) reg_write(REG_SPARE, 8'($urandom_range(0, 255)));
      reg_write(REG_DELIMITER, d);
      no_idle = (p == 1) || ($urandom_range(0, 4) == 0);
      queue_frames(PHASE_BYTES);
    end

    drain_block();
    no_idle = 1'b0;
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("%0d raw bytes sent, %0d encoded bytes checked, %0d frame ends", bytes_in,
             bytes_out, frames_out);
    $display("%0d register writes, delimiters 0x00 0x01 0x0A 0xFF and random", writes);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cfe_pkg.sv
rtl/core/cfe_if.sv
rtl/core/cfe_dp.sv
rtl/core/cfe_ctrl.sv
rtl/core/cobs_frame_encoder_core.sv
tb/sv/cobs_frame_encoder_core_tb.sv
